@@ rtl/bpc_pkg.sv @@
// Package with types and constants for the parenthesization counter.
package bpc_pkg;

  localparam int unsigned MAX_SYMBOLS_DEF = 64;
  localparam int unsigned COUNT_BITS_DEF  = 32;

  localparam logic [7:0] SYM_T   = 8'h54;
  localparam logic [7:0] SYM_F   = 8'h46;
  localparam logic [7:0] SYM_AND = 8'h26;
  localparam logic [7:0] SYM_OR  = 8'h7c;
  localparam logic [7:0] SYM_XOR = 8'h5e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } bpc_in_t;

  typedef struct packed {
    logic [31:0] true_ways;
    logic        too_long;
  } bpc_out_t;

endpackage

@@ rtl/boolean_parenthesization_count.sv @@
// Top level: symbol store, interval count tables and the fill sequencer.
//
// Usage: present one expression character per beat on in_beat with start high;
// it is taken when busy is low. Non-final beats are stored as they are taken.
// The beat with last_symbol set starts the table fill; busy stays high until
// the result appears on out_beat for exactly one cycle with out_valid high.
// The fill writes the n diagonal entries, then visits every span (a,b) in
// order of length. Each span has a setup step, two reads per odd split point
// (the table memories have a single read port), a drain and a write step.
// The result is read back from the table after the last table write.
// Characters beyond MAX_SYMBOLS are dropped; the result then is zero with
// too_long set, returned the cycle after the final beat, without a fill.
// Reset (rst_n low, synchronous) clears the count, overflow flag and
// sequencer; memory contents are not cleared and need not be.
// The receiver cannot stall: each result is shown for one cycle only.
module boolean_parenthesization_count #(
  parameter int unsigned MAX_SYMBOLS = bpc_pkg::MAX_SYMBOLS_DEF,
  parameter int unsigned COUNT_BITS  = bpc_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bpc_pkg::bpc_in_t  in_beat,
  output logic              out_valid,
  output bpc_pkg::bpc_out_t out_beat
);
  import bpc_pkg::*;

  localparam int unsigned IW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int unsigned CW = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned AW = 2 * IW;
  localparam int unsigned TD = 2 ** AW;

  typedef enum logic [2:0] {
    S_IDLE, S_DIAG, S_SPAN, S_RDL, S_RDR, S_DRAIN, S_WRITE, S_DONE
  } state_t;

  logic [7:0]            sym_mem [MAX_SYMBOLS];
  logic [COUNT_BITS-1:0] t_mem [TD];
  logic [COUNT_BITS-1:0] f_mem [TD];

  state_t        state_r;
  logic [CW-1:0] cnt_r;
  logic          ovf_r;
  logic [IW-1:0] a_r, b_r, k_r, len_r;
  logic [1:0]    drain_r;

  // Table read port, read data registered.
  logic [AW-1:0]         rd_addr;
  logic [COUNT_BITS-1:0] t_rd_r, f_rd_r;
  logic [COUNT_BITS-1:0] lt_r, lf_r;
  logic [7:0]            sym_rd_r;
  logic [IW-1:0]         sym_addr;

  logic                  we;
  logic [AW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wt, wf;

  logic                  mac_clr, mac_en;
  logic [COUNT_BITS-1:0] tw, fw;
  logic                  accept;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  function automatic logic [AW-1:0] idx(input logic [IW-1:0] r, input logic [IW-1:0] c);
    idx = {r, c};
  endfunction

  // Read address and symbol address, by state.
  always_comb begin
    rd_addr  = idx(a_r, k_r - IW'(1));
    sym_addr = k_r;
    unique case (state_r)
      S_RDR:   rd_addr = idx(k_r + IW'(1), b_r);
      S_DONE:  rd_addr = idx(a_r, b_r);
      S_DIAG:  sym_addr = a_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    t_rd_r   <= t_mem[rd_addr];
    f_rd_r   <= f_mem[rd_addr];
    sym_rd_r <= sym_mem[sym_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && cnt_r < CW'(MAX_SYMBOLS)) sym_mem[cnt_r[IW-1:0]] <= in_beat.symbol;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      t_mem[wr_addr] <= wt;
      f_mem[wr_addr] <= wf;
    end
  end

  // Op byte for the split issued in the previous cycle (registered symbol read),
  // aligned with the right-hand counts.
  logic          diag_we_r;
  logic [IW-1:0] diag_a_r;
  logic          rdr_r;

  assign mac_en  = rdr_r;
  assign mac_clr = (state_r == S_SPAN);

  always_comb begin
    we      = 1'b0;
    wr_addr = idx(a_r, b_r);
    wt      = tw;
    wf      = fw;
    if (diag_we_r) begin
      we      = 1'b1;
      wr_addr = idx(diag_a_r, diag_a_r);
      wt      = COUNT_BITS'(sym_rd_r == SYM_T);
      wf      = COUNT_BITS'(sym_rd_r == SYM_F);
    end else if (state_r == S_WRITE) begin
      we = 1'b1;
    end
  end

  bpc_mac #(.COUNT_BITS(COUNT_BITS)) u_mac (
    .clk (clk),
    .clr (mac_clr),
    .en  (mac_en),
    .op  (sym_rd_r),
    .lt  (lt_r),
    .lf  (lf_r),
    .rt  (t_rd_r),
    .rf  (f_rd_r),
    .tw  (tw),
    .fw  (fw)
  );

  always_ff @(posedge clk) begin
    if (state_r == S_RDR) begin
      lt_r <= t_rd_r;
      lf_r <= f_rd_r;
    end
    diag_a_r <= a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      a_r       <= '0;
      b_r       <= '0;
      k_r       <= '0;
      len_r     <= '0;
      drain_r   <= '0;
      diag_we_r <= 1'b0;
      rdr_r     <= 1'b0;
      out_valid <= 1'b0;
      out_beat  <= '0;
    end else begin
      out_valid <= 1'b0;
      diag_we_r <= (state_r == S_DIAG);
      rdr_r     <= (state_r == S_RDR);
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (cnt_r < CW'(MAX_SYMBOLS)) cnt_r <= cnt_r + CW'(1);
            if (in_beat.last_symbol) begin
              if (ovf_r || cnt_r >= CW'(MAX_SYMBOLS)) begin
                out_valid <= 1'b1;
                out_beat  <= '{true_ways: '0, too_long: 1'b1};
                cnt_r     <= '0;
                ovf_r     <= 1'b0;
              end else begin
                a_r     <= '0;
                state_r <= S_DIAG;
              end
            end else if (cnt_r >= CW'(MAX_SYMBOLS)) begin
              ovf_r <= 1'b1;
            end
          end
        end
        S_DIAG: begin
          if (CW'(a_r) == cnt_r - CW'(1)) begin
            len_r <= IW'(1);
            a_r   <= '0;
            if (cnt_r == CW'(1)) begin
              // The only diagonal write lands during the first done cycle,
              // so the read-back is held off until that write has landed.
              b_r     <= '0;
              drain_r <= 2'd3;
              state_r <= S_DONE;
            end else begin
              b_r     <= IW'(1);
              state_r <= S_SPAN;
            end
          end else begin
            a_r <= a_r + IW'(1);
          end
        end
        S_SPAN: begin
          k_r <= a_r + IW'(1);
          if (len_r[0]) begin
            drain_r <= 2'd3;
            state_r <= S_DRAIN;
          end else begin
            state_r <= S_RDL;
          end
        end
        S_RDL: state_r <= S_RDR;
        S_RDR: begin
          if (CW'(k_r) + CW'(2) >= CW'(b_r)) begin
            drain_r <= 2'd3;
            state_r <= S_DRAIN;
          end else begin
            k_r     <= k_r + IW'(2);
            state_r <= S_RDL;
          end
        end
        S_DRAIN: begin
          // Wait for the last products to land in the accumulator.
          if (drain_r == 2'd0) state_r <= S_WRITE;
          else drain_r <= drain_r - 2'd1;
        end
        S_WRITE: begin
          if (CW'(b_r) == cnt_r - CW'(1)) begin
            if (CW'(len_r) == cnt_r - CW'(1)) begin
              state_r <= S_DONE;
            end else begin
              len_r   <= len_r + IW'(1);
              a_r     <= '0;
              b_r     <= len_r + IW'(1);
              state_r <= S_SPAN;
            end
          end else begin
            a_r     <= a_r + IW'(1);
            b_r     <= b_r + IW'(1);
            state_r <= S_SPAN;
          end
        end
        S_DONE: begin
          // Last write (or diagonal) is done; read whole-span true count.
          if (drain_r != 2'd1) begin
            drain_r <= drain_r + 2'd1;
          end else begin
            drain_r   <= '0;
            out_valid <= 1'b1;
            out_beat  <= '{true_ways: 32'(t_rd_r), too_long: 1'b0};
            cnt_r     <= '0;
            ovf_r     <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/bpc_mac.sv @@
// Split-step unit: four products of the left and right counts, registered, then accumulated.
module bpc_mac #(
  parameter int unsigned COUNT_BITS = bpc_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  clr,
  input  logic                  en,
  input  logic [7:0]            op,
  input  logic [COUNT_BITS-1:0] lt,
  input  logic [COUNT_BITS-1:0] lf,
  input  logic [COUNT_BITS-1:0] rt,
  input  logic [COUNT_BITS-1:0] rf,
  output logic [COUNT_BITS-1:0] tw,
  output logic [COUNT_BITS-1:0] fw
);
  import bpc_pkg::*;

  logic [COUNT_BITS-1:0] ptt_r, ptf_r, pft_r, pff_r;
  logic [7:0]            op_r;
  logic                  en_r;
  logic [COUNT_BITS-1:0] tw_r, fw_r, tw_nxt, fw_nxt;

  always_ff @(posedge clk) begin
    ptt_r <= COUNT_BITS'(lt * rt);
    ptf_r <= COUNT_BITS'(lt * rf);
    pft_r <= COUNT_BITS'(lf * rt);
    pff_r <= COUNT_BITS'(lf * rf);
    op_r  <= op;
    en_r  <= en;
  end

  always_comb begin
    tw_nxt = tw_r;
    fw_nxt = fw_r;
    if (en_r) begin
      unique case (op_r)
        SYM_AND: begin
          tw_nxt = tw_r + ptt_r;
          fw_nxt = fw_r + pff_r + pft_r + ptf_r;
        end
        SYM_OR: begin
          tw_nxt = tw_r + ptf_r + pft_r + ptt_r;
          fw_nxt = fw_r + pff_r;
        end
        SYM_XOR: begin
          tw_nxt = tw_r + ptf_r + pft_r;
          fw_nxt = fw_r + pff_r + ptt_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      tw_r <= '0;
      fw_r <= '0;
    end else begin
      tw_r <= tw_nxt;
      fw_r <= fw_nxt;
    end
  end

  assign tw = tw_r;
  assign fw = fw_r;

endmodule
